FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the quality score packer.
// Depends on nothing; users must provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define QSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("quality score packer check failed");

// Checked at every clock edge, during reset too.
`define QSP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("quality score packer reset check failed");

`endif

FILE: hdl/qsp_pkg.sv
// Types and constants of the quality score packer.
// Used by the encoder and the top level; depends on nothing.
package qsp_pkg;

    localparam logic [6:0] MODE_RESET     = 7'd40;
    localparam logic [6:0] MODE_KNEE      = 7'd40;
    localparam logic [7:0] WINDOW_FLOOR   = 8'd33;
    localparam logic [7:0] WINDOW_OFFSET  = 8'd7;
    localparam logic [7:0] UPPER_OFFSET   = 8'd4;
    localparam logic [7:0] NEWLINE_CHAR   = 8'd10;
    localparam logic [5:0] RUN_LIMIT      = 6'd55;
    localparam logic [7:0] RUN_BASE       = 8'd199;
    localparam logic [7:0] PAIR_BASE      = 8'd73;
    localparam logic [7:0] TRIPLE_BASE    = 8'd137;
    localparam logic [7:0] LITERAL_OFFSET = 8'd32;
    localparam logic [7:0] NEWLINE_CODE   = 8'd0;

    typedef struct packed {
        logic [5:0] pending;
        logic [7:0] prev;
        logic [7:0] prev_prev;
    } t_pack_state;

    typedef struct packed {
        logic [1:0]  count;
        logic [7:0]  code0;
        logic [7:0]  code1;
        t_pack_state state;
    } t_enc_res;

endpackage

FILE: hdl/qsp_encoder.sv
// Single-pass encoder: one quality character plus packing state to up to two codes.
// Depends on qsp_pkg.
module qsp_encoder (
    input  logic [6:0]           i_mode,
    input  logic [7:0]           i_char,
    input  qsp_pkg::t_pack_state i_state,
    output qsp_pkg::t_enc_res    o_res
);
    import qsp_pkg::*;

    logic [7:0] s8;
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
    logic [7:0] c;
    logic [7:0] j;
    logic [7:0] k;
    logic       c_win;
    logic       c_up;
    logic       j_up;
    logic [5:0] len;
    logic [1:0] n;
    logic [7:0] codes [2];
    logic       newline;

    assign s8    = {1'b0, i_mode};
    assign lo    = (i_mode >= MODE_KNEE) ? s8 - WINDOW_OFFSET : WINDOW_FLOOR;
    assign mid   = lo + UPPER_OFFSET;
    assign hi    = lo + WINDOW_OFFSET;
    assign c     = i_char;
    assign j     = i_state.prev;
    assign k     = i_state.prev_prev;
    assign c_win = (c >= lo) && (c <= hi);
    assign c_up  = (c >= mid) && (c <= hi);
    assign j_up  = (j >= mid) && (j <= hi);

    always_comb begin
        len      = i_state.pending;
        n        = 2'd0;
        codes[0] = NEWLINE_CODE;
        codes[1] = NEWLINE_CODE;
        newline  = 1'b0;
        if (len == 6'd0 && (c == s8 || c_win)) begin
            len = 6'd1;
        end else if (len == 6'd1 && ((c == s8 && j == s8) || (c_up && j_up))) begin
            len = 6'd2;
        end else if (len >= 6'd2 && len < RUN_LIMIT && k == s8 && j == s8 && c == s8) begin
            len = len + 6'd1;
        end else begin
            len = len + 6'd1;
            if ((len > 6'd2 && j == s8 && k == s8) || (len == 6'd2 && j == s8)) begin
                codes[n[0]] = RUN_BASE + {2'b00, len};
                n           = n + 2'd1;
                len         = 6'd1;
            end
            if (len == 6'd3) begin
                if (c_up) begin
                    codes[n[0]] = TRIPLE_BASE + (k - mid) + ((j - mid) << 2)
                                  + ((c - mid) << 4);
                    len = 6'd0;
                end else begin
                    codes[n[0]] = PAIR_BASE + (k - lo) + ((j - lo) << 3);
                    len = 6'd1;
                end
                n = n + 2'd1;
            end
            if (len == 6'd2) begin
                if (c_win) begin
                    codes[n[0]] = PAIR_BASE + (j - lo) + ((c - lo) << 3);
                    len = 6'd0;
                end else begin
                    codes[n[0]] = j - LITERAL_OFFSET;
                    len = 6'd1;
                end
                n = n + 2'd1;
            end
            if (len == 6'd1) begin
                if (c == NEWLINE_CHAR) begin
                    codes[n[0]] = NEWLINE_CODE;
                    n           = n + 2'd1;
                    len         = 6'd0;
                    newline     = 1'b1;
                end else if (!c_win) begin
                    codes[n[0]] = c - LITERAL_OFFSET;
                    n           = n + 2'd1;
                    len         = 6'd0;
                end
            end
        end
    end

    assign o_res.count           = n;
    assign o_res.code0           = codes[0];
    assign o_res.code1           = codes[1];
    assign o_res.state.pending   = len;
    assign o_res.state.prev      = newline ? NEWLINE_CHAR : c;
    assign o_res.state.prev_prev = newline ? 8'd0 : j;

endmodule

FILE: hdl/quality_score_packer_core.sv
// Top level of the quality score packer: state registers, encoder and result queue.
// Depends on qsp_pkg and qsp_encoder.

// Each accepted request is encoded in the cycle it is accepted and its zero, one or two
// codes enter a result queue of QUEUE_DEPTH entries; each code is offered at the output
// from its queue register. A request is taken every cycle as long as the output side
// takes one code per cycle and requests yield at most one code each; a request that
// yields two codes holds the single output port for both of them, so the sustained rate
// is set by the number of codes produced. Requests are taken while the queue has room for
// two codes. Symbols still held in a run or pair are released only by a later request.
module quality_score_packer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    input  logic       i_qual_valid,
    output logic       o_qual_ready,
    input  logic [7:0] i_qual_byte,
    output logic       o_code_valid,
    input  logic       i_code_ready,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run
);
    import qsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [6:0]       r_mode;
    t_pack_state      r_state;
    logic [7:0]       r_fifo_code [QUEUE_DEPTH];
    logic             r_fifo_last [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wr_ptr_1;
    logic [PTR_W-1:0] wr_ptr_2;
    logic [1:0]       push_n;
    logic             accept;
    logic             pop;
    t_enc_res         enc_res;

    qsp_encoder u_encoder (
        .i_mode  (r_mode),
        .i_char  (i_qual_byte),
        .i_state (r_state),
        .o_res   (enc_res)
    );

    assign o_qual_ready  = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_code_valid  = (r_count != '0);
    assign o_code_byte   = r_fifo_code[r_rd_ptr];
    assign o_last_of_run = r_fifo_last[r_rd_ptr];

    assign accept = i_qual_valid && o_qual_ready;
    assign pop    = o_code_valid && i_code_ready;
    assign push_n = accept ? enc_res.count : 2'd0;

    assign wr_ptr_1 = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign wr_ptr_2 = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + PTR_W'(1);

    always_comb begin
        case (push_n)
            2'd1:    n_wr_ptr = wr_ptr_1;
            2'd2:    n_wr_ptr = wr_ptr_2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end else begin
            n_rd_ptr = r_rd_ptr;
        end
        n_count = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_state   <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_state <= enc_res.state;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo_code[r_wr_ptr] <= enc_res.code0;
            r_fifo_last[r_wr_ptr] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            r_fifo_code[wr_ptr_1] <= enc_res.code1;
            r_fifo_last[wr_ptr_1] <= 1'b1;
        end
    end

endmodule

FILE: hdl/qsp_checker.sv
// Port-level checks of the quality score packer and their binding to the top level.
// Depends on assert_macros.svh and quality_score_packer_core.
`include "assert_macros.svh"

module qsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_qual_valid,
    input logic       o_qual_ready,
    input logic [7:0] i_qual_byte,
    input logic       o_code_valid,
    input logic       i_code_ready,
    input logic [7:0] o_code_byte,
    input logic       o_last_of_run
);

    // Reset empties the result queue.
    `QSP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_code_valid)

    // A stalled result stays offered and unchanged.
    `QSP_ASSERT(a_out_hold, o_code_valid && !i_code_ready |=> o_code_valid)
    `QSP_ASSERT(a_out_stable, o_code_valid && !i_code_ready |=> $stable(o_code_byte) && $stable(o_last_of_run))

    // Results appear only after a request was taken.
    `QSP_ASSERT(a_rose_needs_req, $rose(o_code_valid) |-> $past(i_qual_valid && o_qual_ready))

    // Requests are refused only while results are waiting.
    `QSP_ASSERT(a_stall_has_data, !o_qual_ready |-> o_code_valid)

endmodule

bind quality_score_packer_core qsp_checker u_qsp_checker (.*);

FILE: tb/tb_quality_score_packer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for quality_score_packer_core: directed and random character
// streams go in through valid/ready, and every code byte is checked against a predictor.
// Depends only on the RTL of the quality score packer.
module tb_quality_score_packer_core;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD        = 150;
    localparam int NL_CHAR          = 10;
    localparam int NL_CODE          = 0;
    localparam int RUN_MAX          = 55;
    localparam int RUN_CODE_BASE    = 199;
    localparam int PAIR_CODE_BASE   = 73;
    localparam int TRIPLE_CODE_BASE = 137;
    localparam int LIT_OFFSET       = 32;
    localparam int WIN_FLOOR        = 33;
    localparam int WIN_SPAN         = 7;
    localparam int UPPER_OFS        = 4;
    localparam int MODE_KNEE        = 40;
    localparam int MODE_AT_RESET    = 40;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_code;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [6:0] i_cfg_wr_data = '0;
    logic       i_qual_valid  = 1'b0;
    logic [7:0] i_qual_byte   = '0;
    logic       i_code_ready  = 1'b0;
    logic       o_qual_ready;
    logic       o_code_valid;
    logic [7:0] o_code_byte;
    logic       o_last_of_run;

    t_code      code_queue[$];
    logic [6:0] cur_mode   = 7'(MODE_AT_RESET);
    logic [5:0] held_cnt   = '0;
    logic [7:0] last_char  = '0;
    logic [7:0] last_char2 = '0;

    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int sent_cnt    = 0;
    int burst_left  = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int style       = 0;
    int style_left  = 0;

    quality_score_packer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_qual_valid  (i_qual_valid),
        .o_qual_ready  (o_qual_ready),
        .i_qual_byte   (i_qual_byte),
        .o_code_valid  (o_code_valid),
        .i_code_ready  (i_code_ready),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic encode_quality(input logic [7:0] ch);
        int c, s, lo, mid, hi, len, j, k;
        bit c_win, c_up, j_up, nl;
        int outs[$];
        t_code item;
        c = int'(ch);
        s = int'(cur_mode);
        lo = (s >= MODE_KNEE) ? s - WIN_SPAN : WIN_FLOOR;
        mid = lo + UPPER_OFS;
        hi = lo + WIN_SPAN;
        len = int'(held_cnt);
        j = int'(last_char);
        k = int'(last_char2);
        c_win = (c >= lo && c <= hi);
        c_up = (c >= mid && c <= hi);
        j_up = (j >= mid && j <= hi);
        nl = 1'b0;
        if (len == 0 && (c == s || c_win)) begin
            len = 1;
        end else if (len == 1 && ((c == s && j == s) || (c_up && j_up))) begin
            len = 2;
        end else if (len >= 2 && len < RUN_MAX && k == s && j == s && c == s) begin
            len++;
        end else begin
            len++;
            if ((len > 2 && j == s && k == s) || (len == 2 && j == s)) begin
                if (outs.size() < 2)
                    outs.insert(outs.size(), (RUN_CODE_BASE + len) & 8'hFF);
                len = 1;
            end
            if (len == 3) begin
                if (c_up) begin
                    if (outs.size() < 2)
                        outs.insert(outs.size(), (TRIPLE_CODE_BASE + (k - mid)
                            + 4 * (j - mid) + 16 * (c - mid)) & 8'hFF);
                    len = 0;
                end else begin
                    if (outs.size() < 2)
                        outs.insert(outs.size(),
                            (PAIR_CODE_BASE + (k - lo) + 8 * (j - lo)) & 8'hFF);
                    len = 1;
                end
            end
            if (len == 2) begin
                if (c_win) begin
                    if (outs.size() < 2)
                        outs.insert(outs.size(),
                            (PAIR_CODE_BASE + (j - lo) + 8 * (c - lo)) & 8'hFF);
                    len = 0;
                end else begin
                    if (outs.size() < 2)
                        outs.insert(outs.size(), (j - LIT_OFFSET) & 8'hFF);
                    len = 1;
                end
            end
            if (len == 1) begin
                if (c == NL_CHAR) begin
                    len = 0;
                    if (outs.size() < 2) outs.insert(outs.size(), NL_CODE);
                    nl = 1'b1;
                end else if (!c_win) begin
                    if (outs.size() < 2)
                        outs.insert(outs.size(), (c - LIT_OFFSET) & 8'hFF);
                    len = 0;
                end
            end
        end
        held_cnt = 6'(len);
        if (nl) begin
            last_char2 = '0;
            last_char = 8'(NL_CHAR);
        end else begin
            last_char2 = 8'(j);
            last_char = 8'(c);
        end
        foreach (outs[i]) begin
            item.code = 8'(outs[i]);
            item.last = (i == outs.size() - 1);
            code_queue.insert(code_queue.size(), item);
        end
    endtask

    function automatic void note_mismatch(string what, int exp_v, int got_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && o_code_valid && i_code_ready) begin
            if (code_queue.size() == 0) begin
                note_mismatch("code with no request behind it", -1, int'(o_code_byte));
            end else begin
                want = code_queue.pop_front();
                if (o_code_byte !== want.code)
                    note_mismatch("code_byte", int'(want.code), int'(o_code_byte));
                if (o_last_of_run !== want.last)
                    note_mismatch("last_of_run", int'(want.last), int'(o_last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_code_ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            i_code_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
                0: begin
                    i_code_ready <= 1'b1;
                end
                1: begin
                    i_code_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_code_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_code_ready <= (cycle_cnt % 3 != 0);
                end
            endcase
        end
    end

    task automatic send_qual(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_qual_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
        i_qual_valid <= 1'b1;
        i_qual_byte <= b;
        @(posedge i_clk);
        while (!o_qual_ready) @(posedge i_clk);
        burst_left--;
        sent_cnt++;
        encode_quality(b);
    endtask

    // The packer may still hold a request that yields no code, so the task keeps waiting after
    // the last code has been taken before the mode symbol is changed.
    task automatic write_mode(input logic [6:0] m);
        i_qual_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        cur_mode = m;
        i_cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    task automatic test_default_mode();
        logic [7:0] seq[] = '{40, 40, 40, 40, 35, 36, 37, 38, 39, 10, 0, 31, 255, 40, 10};
        foreach (seq[i]) send_qual(seq[i]);
    endtask

    task automatic test_mode_extremes();
        logic [7:0] top_seq[] = '{127, 127, 120, 124, 125, 126, 10};
        logic [7:0] low_seq[] = '{0, 0, 33, 34, 10};
        logic [7:0] nl_seq[]  = '{10, 10, 10, 65, 10};
        write_mode(7'd127);
        foreach (top_seq[i]) send_qual(top_seq[i]);
        write_mode(7'd0);
        foreach (low_seq[i]) send_qual(low_seq[i]);
        write_mode(7'd10);
        foreach (nl_seq[i]) send_qual(nl_seq[i]);
    endtask

    task automatic test_output_hold();
        int lo;
        write_mode(7'd40);
        lo = WIN_FLOOR;
        hold_asked++;
        burst_left = 1000;
        repeat (40) send_qual(8'(lo + $urandom_range(0, 7)));
        burst_left = 0;
    endtask

    task automatic quality_lines(input int n_items);
        int stop_at, run, lo, pick;
        stop_at = sent_cnt + n_items;
        lo = (cur_mode >= MODE_KNEE) ? cur_mode - WIN_SPAN : WIN_FLOOR;
        while (sent_cnt < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 6);
                repeat (run) send_qual({1'b0, cur_mode});
            end else if (pick < 62) begin
                send_qual(8'(lo + $urandom_range(0, WIN_SPAN)));
            end else if (pick < 78) begin
                repeat ($urandom_range(2, 3))
                    send_qual(8'(lo + $urandom_range(UPPER_OFS, WIN_SPAN)));
            end else if (pick < 89) begin
                send_qual(8'(NL_CHAR));
            end else begin
                send_qual(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [6:0] modes[] = '{127, 0, 10, 40, 33, 47, 0, 0};
        foreach (modes[i]) begin
            if (i >= 6) modes[i] = 7'($urandom_range(0, 127));
            write_mode(modes[i]);
            quality_lines(185);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_mode();
        test_mode_extremes();
        test_output_hold();
        test_random_traffic();
        i_qual_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/qsp_pkg.sv
hdl/qsp_encoder.sv
hdl/quality_score_packer_core.sv
hdl/qsp_checker.sv
tb/tb_quality_score_packer_core.sv
